// ===== hw/rtl/md5bc_pkg.sv =====
// ----------------------------------------------------------------------------
// md5bc_pkg
// Shared types, constants and helper functions for the MD5 compression block.
// ----------------------------------------------------------------------------
package md5bc_pkg;

	localparam int WORD_W    = 32;
	localparam int BUF_DEPTH = 16;
	localparam int BUF_AW    = 4;
	localparam int ROUND_W   = 6;

	// beat accepted on the input side
	typedef struct packed {
		logic [WORD_W-1:0] message_word;
		logic              new_message;
	} md5bc_in_t;

	// beat emitted on the result side
	typedef struct packed {
		logic [WORD_W-1:0] digest_word;
		logic [1:0]        digest_index;
		logic              digest_last;
	} md5bc_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} md5bc_state_t;

	// sequencer -> datapath controls
	typedef struct packed {
		logic               busy;
		logic               buf_we;
		logic [BUF_AW-1:0]  buf_waddr;
		logic [BUF_AW-1:0]  buf_raddr;
		logic               init_work;
		logic               round_en;
		logic [ROUND_W-1:0] round;
		logic               finalize;
		logic               emit;
		logic [1:0]         emit_idx;
	} md5bc_ctrl_t;

	localparam logic [WORD_W-1:0] INIT_WORDS [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [WORD_W-1:0] SINE [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotate amounts, indexed by {quarter, round[1:0]}
	localparam logic [4:0] SHIFT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word used by a round
	function automatic logic [BUF_AW-1:0] msg_index(input logic [ROUND_W-1:0] r);
		logic [BUF_AW-1:0] r4;
		logic [BUF_AW-1:0] idx;
		r4 = r[BUF_AW-1:0];
		case (r[5:4])
			2'd0:    idx = r4;
			2'd1:    idx = (r4 << 2) + r4 + 4'd1;
			2'd2:    idx = (r4 << 1) + r4 + 4'd5;
			default: idx = (r4 << 3) - r4;
		endcase
		return idx;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] r);
		return SHIFT[{r[5:4], r[1:0]}];
	endfunction

endpackage

// ===== hw/rtl/md5bc_ram.sv =====
// ----------------------------------------------------------------------------
// md5bc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module md5bc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/md5bc_round.sv =====
// ----------------------------------------------------------------------------
// md5bc_round
// Shared MD5 round unit: round function, constant add, rotate, add into B.
// ----------------------------------------------------------------------------
module md5bc_round
	import md5bc_pkg::*;
(
	input  logic [WORD_W-1:0]  a,
	input  logic [WORD_W-1:0]  b,
	input  logic [WORD_W-1:0]  c,
	input  logic [WORD_W-1:0]  d,
	input  logic [WORD_W-1:0]  m,
	input  logic [ROUND_W-1:0] round,
	output logic [WORD_W-1:0]  b_next
);

	logic [WORD_W-1:0]   fn;
	logic [WORD_W-1:0]   sum;
	logic [2*WORD_W-1:0] rot_wide;

	always_comb begin
		case (round[5:4])
			2'd0:    fn = (b & c) | (~b & d);
			2'd1:    fn = (d & b) | (~d & c);
			2'd2:    fn = b ^ c ^ d;
			default: fn = c ^ (b | ~d);
		endcase
		sum      = fn + a + SINE[round] + m;
		// rotate left: upper half of the doubled word shifted
		rot_wide = {sum, sum} << rot_amount(round);
		b_next   = b + rot_wide[2*WORD_W-1:WORD_W];
	end

endmodule

// ===== hw/rtl/md5bc_ctrl.sv =====
// ----------------------------------------------------------------------------
// md5bc_ctrl
// Sequencer: word counting, round stepping, fold-in and digest emission.
// ----------------------------------------------------------------------------
module md5bc_ctrl
	import md5bc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        new_message,
	output md5bc_ctrl_t ctl
);

	md5bc_state_t       state_q, state_d;
	logic [BUF_AW-1:0]  wc_q, wc_d;
	logic [ROUND_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wc_q    <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			wc_q    <= wc_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		wc_d    = wc_q;
		cnt_d   = cnt_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.buf_waddr = new_message ? '0 : wc_q;
				if (start) begin
					ctl.buf_we = 1'b1;
					wc_d       = ctl.buf_waddr + 4'd1;
					if (ctl.buf_waddr == 4'hF) begin
						state_d = ST_PREP;
					end
				end
			end
			ST_PREP: begin
				ctl.busy      = 1'b1;
				ctl.init_work = 1'b1;
				ctl.buf_raddr = msg_index('0);
				cnt_d         = '0;
				state_d       = ST_ROUND;
			end
			ST_ROUND: begin
				ctl.busy      = 1'b1;
				ctl.round_en  = 1'b1;
				ctl.round     = cnt_q;
				// prefetch next round's word; registered read lands in time
				ctl.buf_raddr = msg_index(cnt_q + 6'd1);
				cnt_d         = cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				ctl.busy     = 1'b1;
				ctl.finalize = 1'b1;
				cnt_d        = '0;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				ctl.busy     = 1'b1;
				ctl.emit     = 1'b1;
				ctl.emit_idx = cnt_q[1:0];
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q[1:0] == 2'd3) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/md5_block_compression.sv =====
// ----------------------------------------------------------------------------
// md5_block_compression
// MD5 compression of 16-word blocks with a running four-word digest.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while busy is low (start high, busy low is a
// beat). The sixteenth word of a block raises busy: the working words are
// loaded and the first message word is prefetched, then 64 rounds run through
// the single shared round unit (one round per cycle, the block buffer read one
// round ahead), then the result is folded into the chaining words and the
// digest beats A, B, C, D are launched.
// Each digest beat shows on result with strobe high for exactly one cycle; the
// receiver has no way to stall, so it must take every strobed beat. The D beat
// (digest_last high) appears in the first cycle after busy drops, so a new
// word may be accepted in the same cycle. A full block is paced by the one
// round per cycle.
// new_message on a word restarts the block at word 0 and reloads the chaining
// words from the MD5 initial values. The block buffer is not cleared at reset;
// only words written in the current block are ever read.
// ----------------------------------------------------------------------------
module md5_block_compression
	import md5bc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  md5bc_in_t  item,
	output logic       strobe,
	output md5bc_out_t result
);

	md5bc_ctrl_t       ctl;
	logic [WORD_W-1:0] buf_rdata;
	logic [WORD_W-1:0] b_next;

	// chaining words (digest state) and working words for the round loop
	logic [WORD_W-1:0] chain_q [4];
	logic [WORD_W-1:0] wa_q, wb_q, wc_q, wd_q;

	// output beat register
	logic       strobe_q;
	md5bc_out_t result_q;

	md5bc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.new_message (item.new_message),
		.ctl         (ctl)
	);

	// block buffer: written on word beats, read during the rounds
	md5bc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BUF_DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (ctl.buf_we),
		.waddr (ctl.buf_waddr),
		.wdata (item.message_word),
		.raddr (ctl.buf_raddr),
		.rdata (buf_rdata)
	);

	md5bc_round u_round (
		.a      (wa_q),
		.b      (wb_q),
		.c      (wc_q),
		.d      (wd_q),
		.m      (buf_rdata),
		.round  (ctl.round),
		.b_next (b_next)
	);

	// chaining words: reload on a new message, fold in after the rounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				chain_q[i] <= INIT_WORDS[i];
			end
		end else if (ctl.buf_we && item.new_message) begin
			for (int i = 0; i < 4; i++) begin
				chain_q[i] <= INIT_WORDS[i];
			end
		end else if (ctl.finalize) begin
			chain_q[0] <= chain_q[0] + wa_q;
			chain_q[1] <= chain_q[1] + wb_q;
			chain_q[2] <= chain_q[2] + wc_q;
			chain_q[3] <= chain_q[3] + wd_q;
		end
	end

	// working words: A <- D, D <- C, C <- B, B <- round output
	always_ff @(posedge clk) begin
		if (ctl.init_work) begin
			wa_q <= chain_q[0];
			wb_q <= chain_q[1];
			wc_q <= chain_q[2];
			wd_q <= chain_q[3];
		end else if (ctl.round_en) begin
			wa_q <= wd_q;
			wd_q <= wc_q;
			wc_q <= wb_q;
			wb_q <= b_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result_q.digest_word  <= chain_q[ctl.emit_idx];
			result_q.digest_index <= ctl.emit_idx;
			result_q.digest_last  <= (ctl.emit_idx == 2'd3);
		end
	end

	assign busy   = ctl.busy;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== hw/rtl/md5bc_checker.sv =====
// ----------------------------------------------------------------------------
// md5bc_checker
// Port-level checks on the digest beat sequence, bound to the top level.
// ----------------------------------------------------------------------------
module md5bc_checker
	import md5bc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       busy,
	input logic       strobe,
	input md5bc_out_t result
);

	// digest beats start at A
	a_first_is_a: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> (result.digest_index == 2'd0))
		else $error("digest burst did not start at word A");

	// beats run A, B, C, D back to back
	a_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (result.digest_index != 2'd3)) |=>
		(strobe && (result.digest_index == $past(result.digest_index) + 2'd1)))
		else $error("digest beats out of sequence");

	// last marker only on D
	a_last_on_d: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.digest_last == (result.digest_index == 2'd3)))
		else $error("digest_last mismatch");

	// block stays busy until the D beat goes out
	a_busy_during_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (result.digest_index != 2'd3)) |-> busy)
		else $error("busy dropped before the digest burst ended");

	// bursts are separated
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.digest_last) |=> !strobe)
		else $error("strobe held after the last digest beat");

endmodule

bind md5_block_compression md5bc_checker u_md5bc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.busy   (busy),
	.strobe (strobe),
	.result (result)
);
